FILE: hdl/day_count_year_fraction_defines.svh
`ifndef DAY_COUNT_YEAR_FRACTION_DEFINES_SVH
`define DAY_COUNT_YEAR_FRACTION_DEFINES_SVH

// Property that must hold in the same cycle as its trigger.
`define DCYF_ASSERT_NOW(name, trig, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (trig) |-> (expr)) \
      else $error("day count year fraction check failed");

// Property that must hold in the cycle after its trigger.
`define DCYF_ASSERT_NEXT(name, trig, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (trig) |=> (expr)) \
      else $error("day count year fraction check failed");

`endif

FILE: hdl/dcyf_pkg.sv
package dcyf_pkg;

   localparam int FRACTION_BITS = 32;

   localparam int MODE_W   = 2;
   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DOM_W    = 5;
   localparam int FRAC_W   = 46;
   localparam int DAY_W    = 22;
   localparam int STATUS_W = 2;

   localparam int QUO_W   = DAY_W - 8;
   localparam int REM_W   = 9;
   localparam int RECIP_W = FRACTION_BITS - 8;
   localparam int PROD_W  = REM_W + RECIP_W;
   localparam int TERM_W  = 18;
   localparam int VAL_W   = QUO_W + FRACTION_BITS + 1;
   localparam int WIDE_W  = ((VAL_W > FRAC_W) ? VAL_W : FRAC_W) + 1;

   localparam int MAX_YEAR    = 9999;
   localparam int YEAR_OFFSET = 400;
   localparam int LAST_DAY    = 31;
   localparam int BOND_MONTH  = 30;
   localparam int BOND_YEAR   = 360;
   localparam int DAYS_YEAR   = 365;

   localparam longint unsigned FRAC_ONE = 64'd1 << FRACTION_BITS;

   localparam logic [REM_W-1:0] DIV360  = REM_W'(BOND_YEAR);
   localparam logic [REM_W-1:0] DIV365  = REM_W'(DAYS_YEAR);
   localparam logic [REM_W-1:0] HALF360 = REM_W'(BOND_YEAR / 2);
   localparam logic [REM_W-1:0] HALF365 = REM_W'(DAYS_YEAR / 2);

   localparam logic [RECIP_W-1:0] RECIP360 = RECIP_W'(FRAC_ONE / 64'd360);
   localparam logic [RECIP_W-1:0] RECIP365 = RECIP_W'(FRAC_ONE / 64'd365);
   localparam logic [REM_W-1:0]   RESID360 = REM_W'(FRAC_ONE % 64'd360);
   localparam logic [REM_W-1:0]   RESID365 = REM_W'(FRAC_ONE % 64'd365);

   // Reciprocal multipliers; each is exact over the input range it is used on.
   localparam int DIV25_W      = 13;
   localparam int DIV25_SHIFT  = 17;
   localparam logic [DIV25_W-1:0] DIV25_MUL = 13'd5243;
   localparam int DIV45_W      = 20;
   localparam int DIV45_SHIFT  = 25;
   localparam logic [DIV45_W-1:0] DIV45_MUL = 20'd745655;
   localparam int DIV365_W     = 23;
   localparam int DIV365_SHIFT = 31;
   localparam logic [DIV365_W-1:0] DIV365_MUL = 23'd5883517;

   typedef enum logic [MODE_W-1:0] {
      MODE_ACT360,
      MODE_ACT365,
      MODE_ACT365F,
      MODE_THIRTY360
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_BAD_DATE,
      STATUS_ORDER
   } status_type;

   typedef struct packed {
      logic             ok;
      logic [DAY_W-1:0] num;
   } date_info_type;

   // Quotient by 25 of a value below 4096.
   function automatic logic [7:0] div25(input logic [11:0] x);
      logic [12+DIV25_W-1:0] p;
      p = (12+DIV25_W)'(x) * (12+DIV25_W)'(DIV25_MUL);
      return p[DIV25_SHIFT +: 8];
   endfunction

   function automatic logic [DOM_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
      logic [DOM_W-1:0] len;
      case (month)
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         4'd2:                    len = leap ? 5'd29 : 5'd28;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

   // Days from March 1 to the first of the month, in a year that starts in March.
   function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] month);
      logic [8:0] start;
      case (month)
         4'd1:    start = 9'd306;
         4'd2:    start = 9'd337;
         4'd3:    start = 9'd0;
         4'd4:    start = 9'd31;
         4'd5:    start = 9'd61;
         4'd6:    start = 9'd92;
         4'd7:    start = 9'd122;
         4'd8:    start = 9'd153;
         4'd9:    start = 9'd184;
         4'd10:   start = 9'd214;
         4'd11:   start = 9'd245;
         4'd12:   start = 9'd275;
         default: start = 9'd0;
      endcase
      return start;
   endfunction

endpackage

FILE: hdl/dcyf_date.sv
module dcyf_date import dcyf_pkg::*; (
   input  logic [YEAR_W-1:0]  year,
   input  logic [MONTH_W-1:0] month,
   input  logic [DOM_W-1:0]   day,
   output date_info_type      info
);

   logic [11:0]       y_div4;
   logic [11:0]       y_div16;
   logic [7:0]        y_cent;
   logic [7:0]        y_quad;
   logic [11:0]       y_rem100;
   logic [11:0]       y_rem400;
   logic              leap;
   logic              early;
   logic [YEAR_W-1:0] adj_year;
   logic [11:0]       adj_div4;
   logic [11:0]       adj_div16;
   logic [7:0]        adj_cent;
   logic [7:0]        adj_quad;

   assign y_div4   = year[YEAR_W-1:2];
   assign y_div16  = {2'b00, year[YEAR_W-1:4]};
   assign y_cent   = div25(y_div4);
   assign y_quad   = div25(y_div16);
   assign y_rem100 = y_div4 - 12'(y_cent) * 12'd25;
   assign y_rem400 = y_div16 - 12'(y_quad) * 12'd25;
   assign leap     = (year[1:0] == 2'd0 && y_rem100 != 12'd0) ||
                     (year[3:0] == 4'd0 && y_rem400 == 12'd0);

   // January and February count as the tail of the previous year.
   assign early     = (month <= 4'd2);
   assign adj_year  = year + YEAR_W'(YEAR_OFFSET) - YEAR_W'(early);
   assign adj_div4  = adj_year[YEAR_W-1:2];
   assign adj_div16 = {2'b00, adj_year[YEAR_W-1:4]};
   assign adj_cent  = div25(adj_div4);
   assign adj_quad  = div25(adj_div16);

   always_comb begin
      info.ok  = (year <= YEAR_W'(MAX_YEAR)) && (month inside {[4'd1:4'd12]}) &&
                 (day != '0) && (day <= month_len(month, leap));
      info.num = DAY_W'(adj_year) * DAY_W'(DAYS_YEAR) + DAY_W'(adj_div4) -
                 DAY_W'(adj_cent) + DAY_W'(adj_quad) + DAY_W'(month_start(month)) +
                 DAY_W'(day);
   end

endmodule

FILE: hdl/dcyf_divmod.sv
module dcyf_divmod import dcyf_pkg::*; (
   input  logic [DAY_W-1:0] num,
   input  logic             sel365,
   output logic [QUO_W-1:0] quo,
   output logic [REM_W-1:0] rem
);

   localparam int P360_W = DAY_W - 3 + DIV45_W;
   localparam int P365_W = DAY_W + DIV365_W;

   logic [DAY_W-4:0]  eighth;
   logic [P360_W-1:0] p360;
   logic [P365_W-1:0] p365;
   logic [DAY_W-1:0]  back;
   logic [DAY_W-1:0]  diff;

   // A quotient by 360 is the quotient by 45 of the value shifted down by three.
   assign eighth = num[DAY_W-1:3];
   assign p360   = P360_W'(eighth) * P360_W'(DIV45_MUL);
   assign p365   = P365_W'(num) * P365_W'(DIV365_MUL);
   assign quo    = sel365 ? p365[DIV365_SHIFT +: QUO_W] : p360[DIV45_SHIFT +: QUO_W];
   assign back   = DAY_W'(quo) * DAY_W'(sel365 ? DIV365 : DIV360);
   assign diff   = num - back;
   assign rem    = diff[REM_W-1:0];

endmodule

FILE: hdl/day_count_year_fraction.sv
// Day-count year fraction unit. Each request carries a convention (actual/360,
// actual/365, actual/365 fixed or 30/360 bond basis) and a start and end date;
// the response gives the day count, the year fraction in unsigned fixed point
// with FRACTION_BITS fraction bits rounded to nearest, and a status (invalid
// date, or end before start, both with zero count and fraction). The unit is a
// five-register pipeline: an input register, the date conversion stage, the
// division of the day count by the year basis, the remainder scaling, and the
// response register after the rounding division. A request is taken every cycle
// while rsp_ready stays high; a stalled response holds the pipeline behind it
// without losing data.
module day_count_year_fraction import dcyf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [YEAR_W-1:0]   req_start_year,
   input  logic [MONTH_W-1:0]  req_start_month,
   input  logic [DOM_W-1:0]    req_start_day,
   input  logic [YEAR_W-1:0]   req_end_year,
   input  logic [MONTH_W-1:0]  req_end_month,
   input  logic [DOM_W-1:0]    req_end_day,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [FRAC_W-1:0]   rsp_fraction,
   output logic [DAY_W-1:0]    rsp_day_count,
   output logic [STATUS_W-1:0] rsp_status
);

   logic ld_out, ld3, ld2, ld1, ld0;

   logic               s0_valid_ff;
   mode_type           s0_mode_ff;
   logic [YEAR_W-1:0]  s0_start_year_ff, s0_end_year_ff;
   logic [MONTH_W-1:0] s0_start_month_ff, s0_end_month_ff;
   logic [DOM_W-1:0]   s0_start_day_ff, s0_end_day_ff;

   date_info_type      start_info, end_info;
   logic [DOM_W-1:0]   bond_start_day, bond_end_day;
   logic [DAY_W-1:0]   bond_start, bond_end;

   logic               s1_valid_ff;
   status_type         s1_status_ff, s1_status_in;
   logic [DAY_W-1:0]   s1_days_ff, s1_days_in;
   logic               s1_sel365_ff, s1_sel365_in;

   logic               s2_valid_ff;
   status_type         s2_status_ff;
   logic [DAY_W-1:0]   s2_days_ff;
   logic               s2_sel365_ff;
   logic [QUO_W-1:0]   s2_quo_ff, s2_quo_in;
   logic [REM_W-1:0]   s2_rem_ff, s2_rem_in;

   logic               s3_valid_ff;
   status_type         s3_status_ff;
   logic [DAY_W-1:0]   s3_days_ff;
   logic               s3_sel365_ff;
   logic [QUO_W-1:0]   s3_quo_ff;
   logic [PROD_W-1:0]  s3_prod_ff, s3_prod_in;
   logic [TERM_W-1:0]  s3_term_ff, s3_term_in;

   logic [QUO_W-1:0]         round_quo;
   logic [FRACTION_BITS-1:0] frac_lo;
   logic [WIDE_W-1:0]        frac_wide;
   logic [FRAC_W-1:0]        rsp_fraction_in;

   logic               rsp_valid_ff;
   logic [FRAC_W-1:0]  rsp_fraction_ff;
   logic [DAY_W-1:0]   rsp_day_count_ff;
   status_type         rsp_status_ff;

   assign ld_out    = !rsp_valid_ff || rsp_ready;
   assign ld3       = !s3_valid_ff || ld_out;
   assign ld2       = !s2_valid_ff || ld3;
   assign ld1       = !s1_valid_ff || ld2;
   assign ld0       = !s0_valid_ff || ld1;
   assign req_ready = ld0;

   dcyf_date u_start_date (
      .year  (s0_start_year_ff),
      .month (s0_start_month_ff),
      .day   (s0_start_day_ff),
      .info  (start_info)
   );

   dcyf_date u_end_date (
      .year  (s0_end_year_ff),
      .month (s0_end_month_ff),
      .day   (s0_end_day_ff),
      .info  (end_info)
   );

   always_comb begin
      bond_start_day = (s0_start_day_ff == DOM_W'(LAST_DAY)) ? DOM_W'(BOND_MONTH)
                                                             : s0_start_day_ff;
      bond_end_day   = (s0_end_day_ff == DOM_W'(LAST_DAY) &&
                        bond_start_day == DOM_W'(BOND_MONTH)) ? DOM_W'(BOND_MONTH)
                                                              : s0_end_day_ff;
      bond_start = DAY_W'(s0_start_year_ff) * DAY_W'(BOND_YEAR) +
                   DAY_W'(s0_start_month_ff) * DAY_W'(BOND_MONTH) + DAY_W'(bond_start_day);
      bond_end   = DAY_W'(s0_end_year_ff) * DAY_W'(BOND_YEAR) +
                   DAY_W'(s0_end_month_ff) * DAY_W'(BOND_MONTH) + DAY_W'(bond_end_day);
      s1_sel365_in = (s0_mode_ff == MODE_ACT365) || (s0_mode_ff == MODE_ACT365F);
      if (!(start_info.ok && end_info.ok)) begin
         s1_status_in = STATUS_BAD_DATE;
         s1_days_in   = '0;
      end else if (end_info.num < start_info.num) begin
         s1_status_in = STATUS_ORDER;
         s1_days_in   = '0;
      end else if (s0_mode_ff == MODE_THIRTY360) begin
         s1_status_in = STATUS_OK;
         s1_days_in   = bond_end - bond_start;
      end else begin
         s1_status_in = STATUS_OK;
         s1_days_in   = end_info.num - start_info.num;
      end
   end

   dcyf_divmod u_days_div (
      .num    (s1_days_ff),
      .sel365 (s1_sel365_ff),
      .quo    (s2_quo_in),
      .rem    (s2_rem_in)
   );

   // The remainder's share of the fraction is r * floor(2^F / d) plus the
   // quotient of r * (2^F mod d) + d / 2 by d, rounded down.
   assign s3_prod_in = PROD_W'(s2_rem_ff) * PROD_W'(s2_sel365_ff ? RECIP365 : RECIP360);
   assign s3_term_in = TERM_W'(s2_rem_ff) * TERM_W'(s2_sel365_ff ? RESID365 : RESID360) +
                       TERM_W'(s2_sel365_ff ? HALF365 : HALF360);

   dcyf_divmod u_round_div (
      .num    (DAY_W'(s3_term_ff)),
      .sel365 (s3_sel365_ff),
      .quo    (round_quo),
      .rem    ()
   );

   always_comb begin
      frac_lo   = FRACTION_BITS'(s3_prod_ff) + FRACTION_BITS'(round_quo);
      frac_wide = (WIDE_W'(s3_quo_ff) << FRACTION_BITS) + WIDE_W'(frac_lo);
      rsp_fraction_in = (frac_wide[WIDE_W-1:FRAC_W] != '0) ? '1
                                                           : frac_wide[FRAC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ld0) begin
         s0_mode_ff        <= mode_type'(req_mode);
         s0_start_year_ff  <= req_start_year;
         s0_start_month_ff <= req_start_month;
         s0_start_day_ff   <= req_start_day;
         s0_end_year_ff    <= req_end_year;
         s0_end_month_ff   <= req_end_month;
         s0_end_day_ff     <= req_end_day;
      end
      if (ld1) begin
         s1_status_ff <= s1_status_in;
         s1_days_ff   <= s1_days_in;
         s1_sel365_ff <= s1_sel365_in;
      end
      if (ld2) begin
         s2_status_ff <= s1_status_ff;
         s2_days_ff   <= s1_days_ff;
         s2_sel365_ff <= s1_sel365_ff;
         s2_quo_ff    <= s2_quo_in;
         s2_rem_ff    <= s2_rem_in;
      end
      if (ld3) begin
         s3_status_ff <= s2_status_ff;
         s3_days_ff   <= s2_days_ff;
         s3_sel365_ff <= s2_sel365_ff;
         s3_quo_ff    <= s2_quo_ff;
         s3_prod_ff   <= s3_prod_in;
         s3_term_ff   <= s3_term_in;
      end
      if (ld_out) begin
         rsp_fraction_ff  <= rsp_fraction_in;
         rsp_day_count_ff <= s3_days_ff;
         rsp_status_ff    <= s3_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ld0) begin
            s0_valid_ff <= req_valid;
         end
         if (ld1) begin
            s1_valid_ff <= s0_valid_ff;
         end
         if (ld2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (ld3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (ld_out) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_fraction  = rsp_fraction_ff;
   assign rsp_day_count = rsp_day_count_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

FILE: hdl/dcyf_checker.sv
`include "day_count_year_fraction_defines.svh"

module dcyf_checker import dcyf_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [FRAC_W-1:0]   rsp_fraction,
   input logic [DAY_W-1:0]    rsp_day_count,
   input logic [STATUS_W-1:0] rsp_status
);

   // A failed request carries neither a count nor a fraction.
   `DCYF_ASSERT_NOW(a_error_clears, rsp_valid && rsp_status != STATUS_OK, rsp_fraction == '0 && rsp_day_count == '0)

   // A good request has a zero fraction exactly when it spans no days.
   `DCYF_ASSERT_NOW(a_zero_span, rsp_valid && rsp_status == STATUS_OK, (rsp_day_count == '0) == (rsp_fraction == '0))

   `DCYF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_fraction) && $stable(rsp_day_count) && $stable(rsp_status))

endmodule

bind day_count_year_fraction dcyf_checker u_dcyf_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_fraction  (rsp_fraction),
   .rsp_day_count (rsp_day_count),
   .rsp_status    (rsp_status)
);

FILE: tb/tb_top.sv
module tb_top import dcyf_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_COUNT = 680;
   localparam int CALM_TAIL = 120;
   localparam longint unsigned LAST_YEAR = 9999;
   localparam longint unsigned FRACTION_CEIL = (64'd1 << FRAC_W) - 1;
   localparam logic [FRAC_W-1:0] ONE_YEAR = FRAC_W'(64'd1 << FRACTION_BITS);

   typedef struct packed {
      mode_type             mode;
      logic [YEAR_W-1:0]    start_year;
      logic [MONTH_W-1:0]   start_month;
      logic [DOM_W-1:0]     start_day;
      logic [YEAR_W-1:0]    end_year;
      logic [MONTH_W-1:0]   end_month;
      logic [DOM_W-1:0]     end_day;
   } date_pair_type;

   typedef struct packed {
      logic [FRAC_W-1:0] fraction;
      logic [DAY_W-1:0]  days;
      status_type        status;
   } accrual_type;

   typedef struct packed {
      date_pair_type dates;
      logic          known;
      accrual_type   want;
   } directed_row_type;

   typedef struct {
      accrual_type want;
      int unsigned serial;
   } pending_type;

   localparam accrual_type NO_RESULT    = '{46'd0, 22'd0, STATUS_OK};
   localparam accrual_type BAD_DATE     = '{46'd0, 22'd0, STATUS_BAD_DATE};
   localparam accrual_type OUT_OF_ORDER = '{46'd0, 22'd0, STATUS_ORDER};

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid;
   logic                req_ready;
   logic [MODE_W-1:0]   req_mode;
   logic [YEAR_W-1:0]   req_start_year;
   logic [MONTH_W-1:0]  req_start_month;
   logic [DOM_W-1:0]    req_start_day;
   logic [YEAR_W-1:0]   req_end_year;
   logic [MONTH_W-1:0]  req_end_month;
   logic [DOM_W-1:0]    req_end_day;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [FRAC_W-1:0]   rsp_fraction;
   logic [DAY_W-1:0]    rsp_day_count;
   logic [STATUS_W-1:0] rsp_status;

   pending_type accruals_due[$];
   int unsigned mismatches = 0;
   int unsigned accepted = 0;
   int unsigned mode_seen[4] = '{0, 0, 0, 0};
   int unsigned status_seen[3] = '{0, 0, 0};
   bit          idling_on = 1'b1;

   directed_row_type directed_rows [25] = '{
      '{'{MODE_ACT360, 14'd2000, 4'd1, 5'd1, 14'd2000, 4'd1, 5'd1}, 1'b1, NO_RESULT},
      '{'{MODE_ACT360, 14'd2001, 4'd1, 5'd1, 14'd2001, 4'd12, 5'd27}, 1'b1,
        '{ONE_YEAR, 22'd360, STATUS_OK}},
      '{'{MODE_ACT365, 14'd2001, 4'd1, 5'd1, 14'd2002, 4'd1, 5'd1}, 1'b1,
        '{ONE_YEAR, 22'd365, STATUS_OK}},
      '{'{MODE_ACT365F, 14'd2003, 4'd3, 5'd1, 14'd2004, 4'd2, 5'd29}, 1'b1,
        '{ONE_YEAR, 22'd365, STATUS_OK}},
      '{'{MODE_THIRTY360, 14'd2000, 4'd1, 5'd1, 14'd2001, 4'd1, 5'd1}, 1'b1,
        '{ONE_YEAR, 22'd360, STATUS_OK}},
      '{'{MODE_THIRTY360, 14'd2000, 4'd1, 5'd31, 14'd2000, 4'd3, 5'd31}, 1'b0, NO_RESULT},
      '{'{MODE_THIRTY360, 14'd2000, 4'd1, 5'd30, 14'd2000, 4'd3, 5'd31}, 1'b0, NO_RESULT},
      '{'{MODE_THIRTY360, 14'd2000, 4'd1, 5'd29, 14'd2000, 4'd3, 5'd31}, 1'b0, NO_RESULT},
      '{'{MODE_THIRTY360, 14'd2000, 4'd2, 5'd29, 14'd2000, 4'd3, 5'd31}, 1'b0, NO_RESULT},
      '{'{MODE_ACT365, 14'd2000, 4'd2, 5'd29, 14'd2100, 4'd2, 5'd28}, 1'b0, NO_RESULT},
      '{'{MODE_ACT360, 14'd0, 4'd1, 5'd1, 14'd9999, 4'd12, 5'd31}, 1'b0, NO_RESULT},
      '{'{MODE_THIRTY360, 14'd0, 4'd1, 5'd1, 14'd9999, 4'd12, 5'd31}, 1'b0, NO_RESULT},
      '{'{MODE_ACT365F, 14'd0, 4'd2, 5'd29, 14'd9999, 4'd12, 5'd31}, 1'b0, NO_RESULT},
      '{'{MODE_ACT360, 14'd10000, 4'd1, 5'd1, 14'd10000, 4'd1, 5'd2}, 1'b1, BAD_DATE},
      '{'{MODE_ACT365, 14'd2000, 4'd1, 5'd1, 14'd16383, 4'd15, 5'd31}, 1'b1, BAD_DATE},
      '{'{MODE_ACT360, 14'd2000, 4'd0, 5'd1, 14'd2000, 4'd1, 5'd1}, 1'b1, BAD_DATE},
      '{'{MODE_THIRTY360, 14'd2000, 4'd1, 5'd1, 14'd2000, 4'd13, 5'd1}, 1'b1, BAD_DATE},
      '{'{MODE_ACT365, 14'd2000, 4'd1, 5'd0, 14'd2000, 4'd1, 5'd1}, 1'b1, BAD_DATE},
      '{'{MODE_ACT360, 14'd1900, 4'd2, 5'd29, 14'd1900, 4'd3, 5'd1}, 1'b1, BAD_DATE},
      '{'{MODE_ACT360, 14'd2100, 4'd2, 5'd28, 14'd2100, 4'd2, 5'd29}, 1'b1, BAD_DATE},
      '{'{MODE_ACT365F, 14'd2000, 4'd2, 5'd30, 14'd2000, 4'd3, 5'd1}, 1'b1, BAD_DATE},
      '{'{MODE_THIRTY360, 14'd2000, 4'd4, 5'd31, 14'd2000, 4'd5, 5'd1}, 1'b1, BAD_DATE},
      '{'{MODE_ACT360, 14'd2000, 4'd1, 5'd2, 14'd2000, 4'd1, 5'd1}, 1'b1, OUT_OF_ORDER},
      '{'{MODE_THIRTY360, 14'd2000, 4'd1, 5'd31, 14'd2000, 4'd1, 5'd30}, 1'b1,
        OUT_OF_ORDER},
      '{'{MODE_ACT365, 14'd10000, 4'd1, 5'd1, 14'd0, 4'd1, 5'd1}, 1'b1, BAD_DATE}
   };

   day_count_year_fraction u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_start_year  (req_start_year),
      .req_start_month (req_start_month),
      .req_start_day   (req_start_day),
      .req_end_year    (req_end_year),
      .req_end_month   (req_end_month),
      .req_end_day     (req_end_day),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_fraction    (rsp_fraction),
      .rsp_day_count   (rsp_day_count),
      .rsp_status      (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned days_in_month(longint unsigned y, longint unsigned m);
      bit leap;
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      case (m)
         4, 6, 9, 11: return 30;
         2:           return leap ? 29 : 28;
         default:     return 31;
      endcase
   endfunction

   function automatic bit date_valid(longint unsigned y, longint unsigned m,
                                     longint unsigned d);
      if (y > LAST_YEAR || m < 1 || m > 12 || d < 1) return 1'b0;
      return d <= days_in_month(y, m);
   endfunction

   // Days counted from a March-based year shifted by 400, so nothing goes negative.
   function automatic longint unsigned serial_day(longint unsigned y, longint unsigned m,
                                                  longint unsigned d);
      longint unsigned yy;
      longint unsigned mp;
      yy = y + 400 - ((m <= 2) ? 1 : 0);
      mp = (m + 9) % 12;
      return yy * 365 + yy / 4 - yy / 100 + yy / 400 + (153 * mp + 2) / 5 + d;
   endfunction

   function automatic logic [FRAC_W-1:0] scaled_fraction(longint unsigned days,
                                                        longint unsigned basis);
      longint unsigned whole;
      longint unsigned part;
      longint unsigned total;
      whole = days / basis;
      part = (((days % basis) << FRACTION_BITS) + basis / 2) / basis;
      if (whole > (FRACTION_CEIL >> FRACTION_BITS)) return FRAC_W'(FRACTION_CEIL);
      total = (whole << FRACTION_BITS) + part;
      return FRAC_W'((total > FRACTION_CEIL) ? FRACTION_CEIL : total);
   endfunction

   function automatic accrual_type predict_accrual(date_pair_type p);
      accrual_type     a;
      longint unsigned y1, m1, d1, y2, m2, d2;
      longint unsigned span, basis;
      a = NO_RESULT;
      y1 = p.start_year;
      m1 = p.start_month;
      d1 = p.start_day;
      y2 = p.end_year;
      m2 = p.end_month;
      d2 = p.end_day;
      if (!date_valid(y1, m1, d1) || !date_valid(y2, m2, d2)) return BAD_DATE;
      if (serial_day(y2, m2, d2) < serial_day(y1, m1, d1)) return OUT_OF_ORDER;
      if (p.mode == MODE_THIRTY360) begin
         if (d1 == 31) d1 = 30;
         if (d2 == 31 && d1 == 30) d2 = 30;
         span = (y2 * 360 + m2 * 30 + d2) - (y1 * 360 + m1 * 30 + d1);
         basis = 360;
      end else begin
         span = serial_day(y2, m2, d2) - serial_day(y1, m1, d1);
         basis = (p.mode == MODE_ACT360) ? 360 : 365;
      end
      a.fraction = scaled_fraction(span, basis);
      a.days = DAY_W'(span);
      return a;
   endfunction

   task automatic random_valid_date(output logic [YEAR_W-1:0] y,
                                    output logic [MONTH_W-1:0] m,
                                    output logic [DOM_W-1:0] d);
      int unsigned len;
      if ($urandom_range(0, 3) == 0) y = YEAR_W'($urandom_range(0, LAST_YEAR));
      else y = YEAR_W'($urandom_range(1890, 2110));
      m = MONTH_W'($urandom_range(1, 12));
      len = days_in_month(y, m);
      if ($urandom_range(0, 2) == 0) d = DOM_W'($urandom_range(len - 2, len));
      else d = DOM_W'($urandom_range(1, len));
   endtask

   // Mostly ordered valid pairs; some reversed, some with a field or all fields garbled.
   task automatic random_pair(output date_pair_type p);
      int unsigned kind;
      int unsigned step;
      int unsigned len;
      logic [YEAR_W+MONTH_W+DOM_W-1:0] a, b;
      date_pair_type q;
      p.mode = mode_type'($urandom_range(0, 3));
      random_valid_date(p.start_year, p.start_month, p.start_day);
      random_valid_date(p.end_year, p.end_month, p.end_day);
      if ($urandom_range(0, 1) == 1) begin
         step = $urandom_range(0, 1);
         if (p.start_year + step <= LAST_YEAR) p.end_year = YEAR_W'(p.start_year + step);
         else p.end_year = p.start_year;
         len = days_in_month(p.end_year, p.end_month);
         if (p.end_day > len) p.end_day = DOM_W'(len);
      end
      kind = $urandom_range(0, 99);
      if (kind < 4) begin
         p.end_year = p.start_year;
         p.end_month = p.start_month;
         p.end_day = p.start_day;
      end
      a = {p.start_year, p.start_month, p.start_day};
      b = {p.end_year, p.end_month, p.end_day};
      if ((kind < 75) == (b < a)) begin
         q = p;
         p.start_year = q.end_year;
         p.start_month = q.end_month;
         p.start_day = q.end_day;
         p.end_year = q.start_year;
         p.end_month = q.start_month;
         p.end_day = q.start_day;
      end
      if (kind >= 85) begin
         case ($urandom_range(0, 6))
            0: p.start_year = YEAR_W'($urandom);
            1: p.start_month = MONTH_W'($urandom);
            2: p.start_day = DOM_W'($urandom);
            3: p.end_year = YEAR_W'($urandom);
            4: p.end_month = MONTH_W'($urandom);
            5: p.end_day = DOM_W'($urandom);
            default: begin
               p.start_year = YEAR_W'($urandom);
               p.start_month = MONTH_W'($urandom);
               p.start_day = DOM_W'($urandom);
               p.end_year = YEAR_W'($urandom);
               p.end_month = MONTH_W'($urandom);
               p.end_day = DOM_W'($urandom);
            end
         endcase
      end
   endtask

   task automatic issue(date_pair_type p, accrual_type want);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= p.mode;
      req_start_year <= p.start_year;
      req_start_month <= p.start_month;
      req_start_day <= p.start_day;
      req_end_year <= p.end_year;
      req_end_month <= p.end_month;
      req_end_day <= p.end_day;
      do @(posedge clock); while (!req_ready);
      accruals_due.push_back('{want: want, serial: accepted});
      accepted++;
      mode_seen[p.mode]++;
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (accruals_due.size() != 0);
   endtask

   task automatic report_mismatch(int unsigned serial, string field,
                                  longint unsigned want, longint unsigned got);
      mismatches++;
      $display("%0t: request %0d %s: expected %0d, got %0d", $time, serial, field,
               want, got);
   endtask

   always @(posedge clock) begin
      pending_type head;
      if (!reset && rsp_valid && rsp_ready) begin
         if (accruals_due.size() == 0) begin
            report_mismatch(accepted, "response with nothing pending, status", 0, rsp_status);
         end else begin
            head = accruals_due.pop_front();
            if (rsp_fraction !== head.want.fraction)
               report_mismatch(head.serial, "fraction", head.want.fraction, rsp_fraction);
            if (rsp_day_count !== head.want.days)
               report_mismatch(head.serial, "day_count", head.want.days, rsp_day_count);
            if (rsp_status !== head.want.status)
               report_mismatch(head.serial, "status", head.want.status, rsp_status);
            status_seen[head.want.status]++;
         end
      end
   end

   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      date_pair_type pair;
      accrual_type   want;
      req_valid <= 1'b0;
      req_mode <= '0;
      req_start_year <= '0;
      req_start_month <= '0;
      req_start_day <= '0;
      req_end_year <= '0;
      req_end_month <= '0;
      req_end_day <= '0;
      reset <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].known) want = directed_rows[i].want;
         else want = predict_accrual(directed_rows[i].dates);
         issue(directed_rows[i].dates, want);
      end
      pause_until_drained();

      for (int n = 0; n < RANDOM_COUNT; n++) begin
         idling_on = (n < RANDOM_COUNT - CALM_TAIL) && ((n / 60) % 4 != 3);
         if (n == RANDOM_COUNT / 2) pause_until_drained();
         random_pair(pair);
         issue(pair, predict_accrual(pair));
      end

      req_valid <= 1'b0;
      while (accruals_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("tb_top: %0d requests (%0d directed); act/360 %0d, act/365 %0d,",
               accepted, $size(directed_rows), mode_seen[0], mode_seen[1]);
      $display("tb_top: act/365F %0d, 30/360 %0d; ok %0d, invalid date %0d,",
               mode_seen[2], mode_seen[3], status_seen[0], status_seen[1]);
      $display("tb_top: end before start %0d; mismatches %0d",
               status_seen[2], mismatches);
      if (mismatches == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/dcyf_pkg.sv
hdl/dcyf_date.sv
hdl/dcyf_divmod.sv
hdl/day_count_year_fraction.sv
hdl/dcyf_checker.sv
tb/tb_top.sv
